/* src/bcle_pkg.sv */
// Shared types and codes for the bounded circular list engine.
package bcle_pkg;

  typedef enum logic [2:0] {
    OP_APPEND   = 3'd0,
    OP_DEL_HEAD = 3'd1,
    OP_DEL_TAIL = 3'd2,
    OP_DEL_POS  = 3'd3,
    OP_READ_ALL = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_TAIL,
    IDX_REM,
    IDX_INC
  } idx_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_DIV_FIN,
    S_READ,
    S_TAKE,
    S_SH_RD,
    S_SH_WR,
    S_RA_RD,
    S_RA_OUT,
    S_EMIT
  } state_e;

  localparam int unsigned DVD_W = 15;
  localparam logic [3:0] DVD_LAST_BIT = 4'(DVD_W - 1);

  typedef struct packed {
    logic [2:0] opcode;
    logic       cnt_zero;
    logic       cnt_full;
    logic       pos_le1;
    logic       div_last;
    logic       idx_zero;
    logic       idx_last;
    logic       idx_next_last;
    logic       out_free;
  } sts_t;

  typedef struct packed {
    logic    load_in;
    logic    st_set;
    status_e st_val;
    logic    res_clr;
    logic    res_cap;
    idx_op_e idx_op;
    logic    div_init;
    logic    div_step;
    logic    wr_append;
    logic    wr_shift;
    logic    rd_en;
    logic    rd_next;
    logic    head_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
    logic    emit_rd;
    logic    emit_last;
  } cmd_t;

endpackage

/* src/bcle_ifs.sv */
// Valid/ready channel interfaces for the list engine's request and result streams.
interface bcle_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] item_value;
  logic signed [15:0] position;

  modport source (output valid, output opcode, output item_value, output position,
                  input ready);
  modport sink (input valid, input opcode, input item_value, input position,
                output ready);
endinterface

interface bcle_out_if #(
  parameter int unsigned CNT_W = 5
);
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         status;
  logic               is_last;
  logic [CNT_W-1:0]   entry_count;

  modport source (output valid, output result_value, output status, output is_last,
                  output entry_count, input ready);
  modport sink (input valid, input result_value, input status, input is_last,
                input entry_count, output ready);
endinterface

/* src/bounded_circular_list_engine_unit.sv */
// Top level of the bounded circular list engine.
// Holds up to LIST_DEPTH signed 32-bit entries in one RAM addressed as a ring from a head
// pointer; one transaction is in work at a time. Append writes in decode and then emits;
// delete head and delete tail read the entry and take it first. Delete at position first
// runs a bit-serial remainder unit when the position exceeds 1, then moves each entry
// behind the removed one down, reading it and then writing it back. Read-all emits each
// entry from the registered RAM read once the output register is free. A result waits
// in the output register while the next transaction is taken. The output interface must
// be built with CNT_W = $clog2(LIST_DEPTH + 1). No clearing pass after reset.
module bounded_circular_list_engine_unit #(
  parameter int unsigned LIST_DEPTH = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  bcle_in_if.sink    in_i,
  bcle_out_if.source out_o
);
  import bcle_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bcle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  bcle_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .opcode_i       (in_i.opcode),
    .item_value_i   (in_i.item_value),
    .position_i     (in_i.position),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .result_value_o (out_o.result_value),
    .status_o       (out_o.status),
    .is_last_o      (out_o.is_last),
    .entry_count_o  (out_o.entry_count)
  );

endmodule

/* src/bcle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bcle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/bcle_ctrl.sv */
// Controller state machine sequencing each list transaction.
module bcle_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output bcle_pkg::cmd_t cmd_o,
  input  bcle_pkg::sts_t sts_i
);
  import bcle_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts_i.opcode) inside
          OP_APPEND: state_d = S_EMIT;
          OP_DEL_HEAD, OP_DEL_TAIL: begin
            state_d = sts_i.cnt_zero ? S_EMIT : S_READ;
          end
          OP_DEL_POS: begin
            if (sts_i.cnt_zero) state_d = S_EMIT;
            else if (sts_i.pos_le1) state_d = S_READ;
            else state_d = S_DIV;
          end
          OP_READ_ALL: begin
            state_d = sts_i.cnt_zero ? S_EMIT : S_RA_RD;
          end
          default: state_d = S_EMIT;
        endcase
      end
      S_DIV: begin
        if (sts_i.div_last) state_d = S_DIV_FIN;
      end
      S_DIV_FIN: state_d = S_READ;
      S_READ:    state_d = S_TAKE;
      S_TAKE: begin
        state_d = (sts_i.idx_zero || sts_i.idx_last) ? S_EMIT : S_SH_RD;
      end
      S_SH_RD: state_d = S_SH_WR;
      S_SH_WR: begin
        state_d = sts_i.idx_next_last ? S_EMIT : S_SH_RD;
      end
      S_RA_RD: state_d = S_RA_OUT;
      S_RA_OUT: begin
        if (sts_i.out_free) state_d = sts_i.idx_last ? S_IDLE : S_RA_RD;
      end
      S_EMIT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.st_val = ST_DONE;
    cmd_o.idx_op = IDX_HOLD;
    in_ready_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_DECODE: begin
        cmd_o.res_clr = 1'b1;
        cmd_o.st_set  = 1'b1;
        unique case (sts_i.opcode) inside
          OP_APPEND: begin
            if (sts_i.cnt_full) begin
              cmd_o.st_val = ST_FULL;
            end else begin
              cmd_o.wr_append = 1'b1;
              cmd_o.cnt_inc   = 1'b1;
            end
          end
          OP_DEL_HEAD, OP_DEL_TAIL: begin
            if (sts_i.cnt_zero) begin
              cmd_o.st_val = ST_EMPTY;
            end else if (sts_i.opcode == OP_DEL_HEAD) begin
              cmd_o.idx_op = IDX_ZERO;
            end else begin
              cmd_o.idx_op = IDX_TAIL;
            end
          end
          OP_DEL_POS: begin
            if (sts_i.cnt_zero) begin
              cmd_o.st_val = ST_EMPTY;
            end else if (sts_i.pos_le1) begin
              cmd_o.idx_op = IDX_ZERO;
            end else begin
              cmd_o.div_init = 1'b1;
            end
          end
          OP_READ_ALL: begin
            if (sts_i.cnt_zero) cmd_o.st_val = ST_EMPTY;
            else cmd_o.idx_op = IDX_ZERO;
          end
          default: cmd_o.st_val = ST_DONE;
        endcase
      end
      S_DIV:     cmd_o.div_step = 1'b1;
      S_DIV_FIN: cmd_o.idx_op   = IDX_REM;
      S_READ:    cmd_o.rd_en    = 1'b1;
      S_TAKE: begin
        cmd_o.res_cap = 1'b1;
        if (sts_i.idx_zero) begin
          cmd_o.head_inc = 1'b1;
          cmd_o.cnt_dec  = 1'b1;
        end else if (sts_i.idx_last) begin
          cmd_o.cnt_dec = 1'b1;
        end
      end
      S_SH_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_next = 1'b1;
      end
      S_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_op   = IDX_INC;
        cmd_o.cnt_dec  = sts_i.idx_next_last;
      end
      S_RA_RD: cmd_o.rd_en = 1'b1;
      S_RA_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_rd   = 1'b1;
          cmd_o.emit_last = sts_i.idx_last;
          if (!sts_i.idx_last) cmd_o.idx_op = IDX_INC;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
        end
      end
      default: cmd_o.emit = 1'b0;
    endcase
  end

`ifndef ASSERT_OFF
  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result loaded while output register occupied");

  a_one_mem_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.wr_append, cmd_o.wr_shift, cmd_o.rd_en}))
    else $error("more than one memory access in a cycle");
`endif

endmodule

/* src/bcle_dp.sv */
// Datapath: entry memory, head and count, remainder unit and result register.
module bcle_dp #(
  parameter int unsigned LIST_DEPTH = 16,
  localparam int unsigned AW = $clog2(LIST_DEPTH),
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] item_value_i,
  input  logic signed [15:0] position_i,
  input  bcle_pkg::cmd_t     cmd_i,
  output bcle_pkg::sts_t     sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic [1:0]         status_o,
  output logic               is_last_o,
  output logic [CW-1:0]      entry_count_o
);
  import bcle_pkg::*;

  logic [2:0]       opcode_q;
  logic [31:0]      val_q;
  logic [15:0]      pos_q;
  logic [AW-1:0]    head_q;
  logic [CW-1:0]    cnt_q;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    rem_q;
  logic [DVD_W-1:0] dvd_q;
  logic [3:0]       dbit_q;
  logic [31:0]      res_q;
  status_e          st_q;
  logic             out_valid_q;
  logic [31:0]      out_val_q;
  status_e          out_st_q;
  logic             out_last_q;
  logic [CW-1:0]    out_cnt_q;

  logic [CW:0]      cnt_x, idx_p1, idx_p2;
  logic [CW:0]      rem_sh, rem_diff;
  logic [CW-1:0]    rem_nx;
  logic             out_free;
  logic             wr_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [31:0]      wr_data, rd_data;

  assign cnt_x    = {1'b0, cnt_q};
  assign idx_p1   = {1'b0, idx_q} + (CW+1)'(1);
  assign idx_p2   = {1'b0, idx_q} + (CW+1)'(2);
  assign rem_sh   = {rem_q, dvd_q[DVD_W-1]};
  assign rem_diff = rem_sh - cnt_x;
  assign rem_nx   = (rem_sh >= cnt_x) ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.opcode        = opcode_q;
    sts_o.cnt_zero      = (cnt_q == '0);
    sts_o.cnt_full      = (cnt_q == CW'(LIST_DEPTH));
    sts_o.pos_le1       = pos_q[15] || (pos_q[14:1] == '0);
    sts_o.div_last      = (dbit_q == '0);
    sts_o.idx_zero      = (idx_q == '0);
    sts_o.idx_last      = (idx_p1 == cnt_x);
    sts_o.idx_next_last = (idx_p2 == cnt_x);
    sts_o.out_free      = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      opcode_q <= opcode_i;
      val_q    <= item_value_i;
      pos_q    <= position_i;
    end
    if (cmd_i.div_init) begin
      rem_q  <= '0;
      dvd_q  <= pos_q[DVD_W-1:0] - DVD_W'(1);
      dbit_q <= DVD_LAST_BIT;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_nx;
      dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
      dbit_q <= dbit_q - 4'd1;
    end
    if (cmd_i.res_clr) begin
      res_q <= '0;
    end else if (cmd_i.res_cap) begin
      res_q <= rd_data;
    end
    if (cmd_i.st_set) begin
      st_q <= cmd_i.st_val;
    end
    idx_q <= idx_d;
    if (cmd_i.emit) begin
      out_val_q  <= cmd_i.emit_rd ? rd_data : res_q;
      out_st_q   <= cmd_i.emit_rd ? ST_DONE : st_q;
      out_last_q <= cmd_i.emit_last;
      out_cnt_q  <= cnt_q;
    end
  end

  always_comb begin
    case (cmd_i.idx_op)
      IDX_ZERO: idx_d = '0;
      IDX_TAIL: idx_d = cnt_q - CW'(1);
      IDX_REM:  idx_d = rem_q;
      IDX_INC:  idx_d = idx_p1[CW-1:0];
      default:  idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.head_inc) head_q <= head_q + AW'(1);
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign wr_en   = cmd_i.wr_append || cmd_i.wr_shift;
  assign wr_addr = head_q + (cmd_i.wr_append ? cnt_q[AW-1:0] : idx_q[AW-1:0]);
  assign wr_data = cmd_i.wr_append ? val_q : rd_data;
  assign rd_addr = head_q + (cmd_i.rd_next ? idx_p1[AW-1:0] : idx_q[AW-1:0]);

  bcle_ram #(
    .WIDTH (32),
    .DEPTH (2 ** AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_val_q;
  assign status_o       = out_st_q;
  assign is_last_o      = out_last_q;
  assign entry_count_o  = out_cnt_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(LIST_DEPTH))
    else $error("entry count beyond list depth");

  a_dec_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> (cnt_q != '0))
    else $error("removal from an empty list");

  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_append |-> (cnt_q != CW'(LIST_DEPTH)))
    else $error("append written into a full list");
`endif

endmodule
